// ----- hdl/nbody_pairwise_gravity_force_unit_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef NBODY_PAIRWISE_GRAVITY_FORCE_UNIT_DEFINES_SVH
`define NBODY_PAIRWISE_GRAVITY_FORCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NBPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define NBPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/nbpg_pkg.sv -----
package nbpg_pkg;

  localparam int BODY_MAX_DEF = 64;

  localparam int POS_W   = 32;
  localparam int MASS_W  = 16;
  localparam int GRAV_W  = 32;
  localparam int DIST_W  = 31;
  localparam int FORCE_W = 64;
  localparam int INDEX_W = 6;

  // Shared multiplier: A up to 66 bits, B up to 33 bits
  localparam int MA_W = 66;
  localparam int MB_W = 33;
  localparam int MP_W = MA_W + MB_W;

  // Square root of a 66-bit sum of squares
  localparam int SQ_IN_W  = 66;
  localparam int SQ_OUT_W = SQ_IN_W / 2;

  // Divider: (k * |d|) << 12 over r cubed
  localparam int DIV_SHIFT = 12;
  localparam int NUM_W     = 97 + DIV_SHIFT;
  localparam int DEN_W     = MP_W;

  localparam int ACC_W = NUM_W + 9;

  localparam logic [GRAV_W-1:0] GRAV_RST     = 32'd733654;
  localparam logic [DIST_W-1:0] MIN_DIST_RST = 31'd7;

  localparam logic REG_GRAV_CONST = 1'b0;
  localparam logic REG_MIN_DIST   = 1'b1;

endpackage

// ----- hdl/nbpg_mul.sv -----
module nbpg_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [nbpg_pkg::MA_W-1:0] a,
  input  logic [nbpg_pkg::MB_W-1:0] b,
  output logic [nbpg_pkg::MP_W-1:0] prod,
  output logic                    done
);
  import nbpg_pkg::*;

  localparam int CW = $clog2(MB_W);

  logic            run_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [MP_W-1:0] a_r;
  logic [MB_W-1:0] b_r;
  logic [MP_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CW'(MB_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      a_r   <= MP_W'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

// ----- hdl/nbpg_sqrt.sv -----
module nbpg_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nbpg_pkg::SQ_IN_W-1:0]  radicand,
  output logic [nbpg_pkg::SQ_OUT_W-1:0] root,
  output logic                         done
);
  import nbpg_pkg::*;

  localparam int CW    = $clog2(SQ_OUT_W);
  localparam int REM_W = SQ_OUT_W + 3;

  logic                run_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [SQ_IN_W-1:0]  s_r;
  logic [REM_W-1:0]    rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [REM_W-1:0]    rem2;
  logic [REM_W-1:0]    trial;

  assign rem2  = {rem_r[REM_W-3:0], s_r[SQ_IN_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CW'(SQ_OUT_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one root bit per cycle, two radicand bits consumed
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= '0;
      s_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      s_r   <= s_r << 2;
      if (rem2 >= trial) begin
        rem_r  <= rem2 - trial;
        root_r <= {root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem2;
        root_r <= {root_r[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ----- hdl/nbpg_div.sv -----
module nbpg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nbpg_pkg::NUM_W-1:0] num,
  input  logic [nbpg_pkg::DEN_W-1:0] den,
  output logic [nbpg_pkg::NUM_W-1:0] quot,
  output logic                       done
);
  import nbpg_pkg::*;

  localparam int CW    = $clog2(NUM_W);
  localparam int REM_W = DEN_W + 1;

  logic             run_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;
  logic [REM_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;
  logic [REM_W-1:0] rem2;
  logic             fits;

  assign rem2 = {rem_r[REM_W-2:0], n_r[NUM_W-1]};
  assign fits = rem2 >= REM_W'(d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CW'(NUM_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      n_r   <= n_r << 1;
      q_r   <= {q_r[NUM_W-2:0], fits};
      rem_r <= fits ? rem2 - REM_W'(d_r) : rem2;
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

// ----- hdl/nbody_pairwise_gravity_force_unit.sv -----
// All-pairs 2D gravity force unit.
// Input channel (in_*): one body per transaction, position in Q16.16 and
// mass in Q10.6. Bodies are stored in load order; a transaction with
// in_last_body set ends the set and starts the force computation. Bodies
// beyond BODY_MAX are discarded and flagged on every result as out_dropped.
// Output channel (out_*): one result per stored body, in index order, with
// the summed force in Q32.32, saturated; out_last_result marks the last.
// Configuration (cfg_*): grav_const at index 0, min_dist at index 1; write
// while idle. cfg_ready is always high.
// A body that does not end the set is taken without a stall. After the
// last body, every ordered pair of distinct bodies runs on one shared 66x33
// shift-add multiplier (seven products), a 33-step square root and two
// 109-step divider passes; pairs at or inside min_dist skip the products
// after the square root and both divider passes. Each body also takes one
// product of its own, grav_const times its mass.
// in_stall stays high from the last body until the final result is taken.
// A stalled result holds its payload and the sequencer waits for it.
// Reset (synchronous, rst_n low) empties the set and restores the register
// defaults; stored positions are not cleared.
module nbody_pairwise_gravity_force_unit #(
  parameter int BODY_MAX = nbpg_pkg::BODY_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [nbpg_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [nbpg_pkg::POS_W-1:0]   in_pos_y,
  input  logic [nbpg_pkg::MASS_W-1:0]         in_body_mass,
  input  logic                                in_last_body,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nbpg_pkg::INDEX_W-1:0]        out_body_index,
  output logic signed [nbpg_pkg::FORCE_W-1:0] out_force_x,
  output logic signed [nbpg_pkg::FORCE_W-1:0] out_force_y,
  output logic                                out_dropped,
  output logic                                out_last_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [nbpg_pkg::GRAV_W-1:0]         cfg_data
);
  import nbpg_pkg::*;
  `include "nbody_pairwise_gravity_force_unit_defines.svh"

  localparam int IDX_W = $clog2(BODY_MAX);
  localparam int CNT_W = $clog2(BODY_MAX + 1);
  localparam int ENT_W = 2 * POS_W + MASS_W;
  localparam int D_W   = POS_W + 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDI  = 5'd1;
  localparam logic [4:0] S_LDI  = 5'd2;
  localparam logic [4:0] S_GM   = 5'd3;
  localparam logic [4:0] S_RDJ  = 5'd4;
  localparam logic [4:0] S_LDJ  = 5'd5;
  localparam logic [4:0] S_DX2  = 5'd6;
  localparam logic [4:0] S_DY2  = 5'd7;
  localparam logic [4:0] S_SQRT = 5'd8;
  localparam logic [4:0] S_R2   = 5'd9;
  localparam logic [4:0] S_R3   = 5'd10;
  localparam logic [4:0] S_K    = 5'd11;
  localparam logic [4:0] S_KX   = 5'd12;
  localparam logic [4:0] S_DIVX = 5'd13;
  localparam logic [4:0] S_KY   = 5'd14;
  localparam logic [4:0] S_DIVY = 5'd15;
  localparam logic [4:0] S_NXTJ = 5'd16;
  localparam logic [4:0] S_EMIT = 5'd17;

  // body store
  logic [ENT_W-1:0] mem [BODY_MAX];
  logic [ENT_W-1:0] rd_q_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  logic [4:0]        state_r, state_nxt;
  logic              launched_r, launched_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [GRAV_W-1:0] grav_r;
  logic [DIST_W-1:0] min_dist_r;

  logic signed [POS_W-1:0] xi_r, yi_r;
  logic [MASS_W-1:0]       mi_r, mj_r;
  logic [47:0]             gm_r;
  logic signed [D_W-1:0]   dx_r, dy_r;
  logic [SQ_IN_W-1:0]      sumsq_r;
  logic [SQ_OUT_W-1:0]     r_r;
  logic [MA_W-1:0]         r2_r;
  logic [DEN_W-1:0]        r3_r;
  logic [63:0]             k_r;
  logic signed [ACC_W-1:0] accx_r, accy_r;

  logic [D_W-1:0] magx, magy;
  logic signed [D_W-1:0] dxj, dyj;

  logic              mul_start, mul_done;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;
  logic              sq_start, sq_done;
  logic [SQ_OUT_W-1:0] sq_root;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_q;
  logic [ACC_W-1:0]  term;

  logic [INDEX_W-1:0]        oidx_r;
  logic [FORCE_W-1:0]        ofx_r, ofy_r;
  logic                      odrop_r, olast_r;
  logic                      load_out;

  function automatic logic [FORCE_W-1:0] sat64(input logic [ACC_W-1:0] v);
    logic [ACC_W-FORCE_W:0] top;
    top = v[ACC_W-1:FORCE_W-1];
    if ((&top) || !(|top)) begin
      sat64 = v[FORCE_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat64 = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      sat64 = {1'b0, {(FORCE_W-1){1'b1}}};
    end
  endfunction

  nbpg_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(mul_p), .done(mul_done)
  );

  nbpg_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sumsq_r),
    .root(sq_root), .done(sq_done)
  );

  nbpg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({mul_p[96:0], {DIV_SHIFT{1'b0}}}), .den(r3_r),
    .quot(div_q), .done(div_done)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en     = (state_r == S_IDLE) && in_valid && (count_r < CNT_W'(BODY_MAX));
  assign rd_addr   = (state_r == S_RDI) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= {in_pos_x, in_pos_y, in_body_mass};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign dxj  = D_W'($signed(rd_q_r[ENT_W-1 -: POS_W])) - D_W'(xi_r);
  assign dyj  = D_W'($signed(rd_q_r[MASS_W +: POS_W])) - D_W'(yi_r);
  assign magx = dx_r[D_W-1] ? D_W'(-dx_r) : D_W'(dx_r);
  assign magy = dy_r[D_W-1] ? D_W'(-dy_r) : D_W'(dy_r);
  assign term = ACC_W'(div_q);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_GM: begin
        mul_a = MA_W'(grav_r);
        mul_b = MB_W'(mi_r);
      end
      S_DX2: begin
        mul_a = MA_W'(magx);
        mul_b = magx;
      end
      S_DY2: begin
        mul_a = MA_W'(magy);
        mul_b = magy;
      end
      S_R2: begin
        mul_a = MA_W'(r_r);
        mul_b = r_r;
      end
      S_R3: begin
        mul_a = r2_r;
        mul_b = r_r;
      end
      S_K: begin
        mul_a = MA_W'(gm_r);
        mul_b = MB_W'(mj_r);
      end
      S_KX: begin
        mul_a = MA_W'(k_r);
        mul_b = magx;
      end
      S_KY: begin
        mul_a = MA_W'(k_r);
        mul_b = magy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    mul_start    = 1'b0;
    sq_start     = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (count_r < CNT_W'(BODY_MAX)) begin
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_body) begin
            n_nxt     = count_nxt;
            i_nxt     = '0;
            state_nxt = S_RDI;
          end
        end
      end
      S_RDI: state_nxt = S_LDI;
      S_LDI: state_nxt = S_GM;
      S_RDJ: begin
        if (j_r == n_r) begin
          load_out  = 1'b1;
          state_nxt = S_EMIT;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          state_nxt = S_LDJ;
        end
      end
      S_LDJ: state_nxt = S_DX2;
      S_GM, S_DX2, S_DY2, S_R2, S_R3, S_K, S_KX, S_KY: begin
        if (!launched_r) begin
          mul_start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (mul_done) begin
          launched_nxt = 1'b0;
          case (state_r)
            S_GM: begin
              j_nxt     = '0;
              state_nxt = S_RDJ;
            end
            S_DX2:   state_nxt = S_DY2;
            S_DY2:   state_nxt = S_SQRT;
            S_R2:    state_nxt = S_R3;
            S_R3:    state_nxt = S_K;
            S_K:     state_nxt = S_KX;
            S_KX:    state_nxt = S_DIVX;
            default: state_nxt = S_DIVY;
          endcase
        end
      end
      S_SQRT: begin
        if (!launched_r) begin
          sq_start     = 1'b1;
          launched_nxt = 1'b1;
        end else if (sq_done) begin
          launched_nxt = 1'b0;
          // drop pairs at or inside the cutoff
          state_nxt    = (sq_root <= SQ_OUT_W'(min_dist_r)) ? S_NXTJ : S_R2;
        end
      end
      S_DIVX, S_DIVY: begin
        if (!launched_r) begin
          div_start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = (state_r == S_DIVX) ? S_KY : S_NXTJ;
        end
      end
      S_NXTJ: begin
        j_nxt     = j_r + 1'b1;
        state_nxt = S_RDJ;
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (i_r + 1'b1 == n_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RDI;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      n_r        <= '0;
      i_r        <= '0;
      j_r        <= '0;
      grav_r     <= GRAV_RST;
      min_dist_r <= MIN_DIST_RST;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      n_r        <= n_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRAV_CONST) begin
          grav_r <= cfg_data;
        end else begin
          min_dist_r <= cfg_data[DIST_W-1:0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_LDI: begin
        xi_r   <= rd_q_r[ENT_W-1 -: POS_W];
        yi_r   <= rd_q_r[MASS_W +: POS_W];
        mi_r   <= rd_q_r[MASS_W-1:0];
        accx_r <= '0;
        accy_r <= '0;
      end
      S_LDJ: begin
        dx_r <= dxj;
        dy_r <= dyj;
        mj_r <= rd_q_r[MASS_W-1:0];
      end
      S_GM:   if (mul_done) gm_r <= mul_p[47:0];
      S_DX2:  if (mul_done) sumsq_r <= mul_p[SQ_IN_W-1:0];
      S_DY2:  if (mul_done) sumsq_r <= sumsq_r + mul_p[SQ_IN_W-1:0];
      S_SQRT: if (sq_done) r_r <= sq_root;
      S_R2:   if (mul_done) r2_r <= mul_p[MA_W-1:0];
      S_R3:   if (mul_done) r3_r <= mul_p;
      S_K:    if (mul_done) k_r <= mul_p[63:0];
      S_DIVX: begin
        if (div_done) accx_r <= dx_r[D_W-1] ? accx_r - term : accx_r + term;
      end
      S_DIVY: begin
        if (div_done) accy_r <= dy_r[D_W-1] ? accy_r - term : accy_r + term;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      oidx_r  <= INDEX_W'(i_r);
      ofx_r   <= sat64(accx_r);
      ofy_r   <= sat64(accy_r);
      odrop_r <= ovf_r;
      olast_r <= (i_r + 1'b1 == n_r);
    end
  end

  assign out_valid       = (state_r == S_EMIT);
  assign out_body_index  = oidx_r;
  assign out_force_x     = ofx_r;
  assign out_force_y     = ofy_r;
  assign out_dropped     = odrop_r;
  assign out_last_result = olast_r;

  `NBPG_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(BODY_MAX), "body count over capacity")
  `NBPG_ASSERT_IMP(a_emit_index, clk, rst_n, out_valid, i_r < n_r && n_r != '0, "result index outside set")
  `NBPG_ASSERT_NXT(a_last_clears, clk, rst_n, out_valid && !out_stall && out_last_result, state_r == S_IDLE && count_r == '0, "set not cleared after last result")

endmodule

// ----- dv/tb_nbody_pairwise_gravity_force_unit.sv -----
module tb_nbody_pairwise_gravity_force_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import nbpg_pkg::*;

  localparam int NBODY      = BODY_MAX_DEF;
  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_LEN   = 3000;

  typedef struct {
    logic [INDEX_W-1:0]        idx;
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    logic                      dropped;
    logic                      last;
  } force_t;

  class force_scoreboard;
    logic [POS_W-1:0]  xs[NBODY];
    logic [POS_W-1:0]  ys[NBODY];
    logic [MASS_W-1:0] ms[NBODY];
    int                n_bodies;
    bit                overflowed;
    logic [GRAV_W-1:0] grav;
    logic [DIST_W-1:0] min_dist;
    force_t            pending_forces[$];
    int                errors;
    int                n_checked;
    int                n_sets;

    function new();
      n_bodies   = 0;
      overflowed = 1'b0;
      grav       = GRAV_RST;
      min_dist   = MIN_DIST_RST;
      errors     = 0;
      n_checked  = 0;
      n_sets     = 0;
    endfunction

    function void write_reg(logic index, logic [GRAV_W-1:0] data);
      if (index == REG_GRAV_CONST) grav = data;
      else min_dist = data[DIST_W-1:0];
    endfunction

    function logic [63:0] int_sqrt(logic [127:0] s);
      logic [63:0]  res;
      logic [63:0]  cand;
      logic [127:0] sq;
      res = '0;
      for (int b = 34; b >= 0; b--) begin
        cand = res | (64'd1 << b);
        sq = {64'd0, cand} * {64'd0, cand};
        if (s >= sq) res = cand;
      end
      return res;
    endfunction

    function logic signed [127:0] pair_term(logic [63:0] k, logic signed [63:0] d,
                                            logic [127:0] r3);
      logic [63:0]  mag;
      logic [127:0] num;
      logic [127:0] q;
      mag = (d < 0) ? -d : d;
      num = ({64'd0, k} * {64'd0, mag}) << DIV_SHIFT;
      q = num / r3;
      return (d < 0) ? -$signed(q) : $signed(q);
    endfunction

    function logic signed [63:0] saturate(logic signed [127:0] a);
      if (a > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (a < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return a[63:0];
    endfunction

    function void compute_forces();
      force_t               f;
      logic signed [127:0]  sum_x;
      logic signed [127:0]  sum_y;
      logic signed [63:0]   xi;
      logic signed [63:0]   yi;
      logic signed [63:0]   dx;
      logic signed [63:0]   dy;
      logic [63:0]          mx;
      logic [63:0]          my;
      logic [63:0]          gm;
      logic [63:0]          k;
      logic [63:0]          r;
      logic [127:0]         r3;
      for (int i = 0; i < n_bodies; i++) begin
        sum_x = '0;
        sum_y = '0;
        xi = $signed(xs[i]);
        yi = $signed(ys[i]);
        gm = {32'd0, grav} * {48'd0, ms[i]};
        for (int j = 0; j < n_bodies; j++) begin
          if (i == j) continue;
          dx = $signed(xs[j]) - xi;
          dy = $signed(ys[j]) - yi;
          mx = (dx < 0) ? -dx : dx;
          my = (dy < 0) ? -dy : dy;
          r = int_sqrt({64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my});
          if (r <= {33'd0, min_dist}) continue;
          r3 = {64'd0, r} * {64'd0, r} * {64'd0, r};
          k = gm * {48'd0, ms[j]};
          sum_x = sum_x + pair_term(k, dx, r3);
          sum_y = sum_y + pair_term(k, dy, r3);
        end
        f.idx     = i[INDEX_W-1:0];
        f.fx      = saturate(sum_x);
        f.fy      = saturate(sum_y);
        f.dropped = overflowed;
        f.last    = (i + 1 == n_bodies);
        pending_forces.push_back(f);
      end
      n_bodies   = 0;
      overflowed = 1'b0;
      n_sets++;
    endfunction

    function void note_body(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [MASS_W-1:0] m, logic last);
      if (n_bodies < NBODY) begin
        xs[n_bodies] = x;
        ys[n_bodies] = y;
        ms[n_bodies] = m;
        n_bodies++;
      end else begin
        overflowed = 1'b1;
      end
      if (last) compute_forces();
    endfunction

    function void check_force(force_t got);
      force_t want;
      if (pending_forces.size() == 0) begin
        $error("unexpected result for body %0d", got.idx);
        errors++;
        return;
      end
      want = pending_forces.pop_front();
      n_checked++;
      if (got.idx !== want.idx) begin
        $error("body_index expected %0d got %0d", want.idx, got.idx);
        errors++;
      end
      if (got.fx !== want.fx) begin
        $error("force_x expected %0d got %0d", want.fx, got.fx);
        errors++;
      end
      if (got.fy !== want.fy) begin
        $error("force_y expected %0d got %0d", want.fy, got.fy);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped expected %0d got %0d", want.dropped, got.dropped);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_result expected %0d got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [POS_W-1:0]   in_pos_x;
  logic signed [POS_W-1:0]   in_pos_y;
  logic [MASS_W-1:0]         in_body_mass;
  logic                      in_last_body;
  logic                      out_valid;
  logic                      out_stall;
  logic [INDEX_W-1:0]        out_body_index;
  logic signed [FORCE_W-1:0] out_force_x;
  logic signed [FORCE_W-1:0] out_force_y;
  logic                      out_dropped;
  logic                      out_last_result;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_index;
  logic [GRAV_W-1:0]         cfg_data;

  force_scoreboard sb;
  bit              hold_req;
  int              bodies_sent;
  int              idle_cycles;

  nbody_pairwise_gravity_force_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_body_mass    (in_body_mass),
    .in_last_body    (in_last_body),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_body_index  (out_body_index),
    .out_force_x     (out_force_x),
    .out_force_y     (out_force_y),
    .out_dropped     (out_dropped),
    .out_last_result (out_last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Stall-free stretches come from the zero draws.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[nbody_pairwise_gravity_force_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_body(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                           logic [MASS_W-1:0] m, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pos_x     <= x;
    in_pos_y     <= y;
    in_body_mass <= m;
    in_last_body <= last;
    do @(posedge clk); while (in_stall);
    sb.note_body(x, y, m, last);
    bodies_sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic index, logic [GRAV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_forces.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic random_set(int n, bit clustered);
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    bx = $urandom();
    by = $urandom();
    for (int i = 0; i < n; i++) begin
      if (clustered) begin
        x = bx + $urandom_range(0, 64) - 32;
        y = by + $urandom_range(0, 64) - 32;
      end else begin
        x = $urandom();
        y = $urandom();
      end
      send_body(x, y, MASS_W'($urandom_range(0, 65535)), i == n - 1);
    end
  endtask

  // Receiver: stall for a drawn number of cycles, or for the hold length when a hold is requested, before each result.
  initial begin
    int     wait_cycles;
    force_t got;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        wait_cycles = HOLD_LEN;
        hold_req = 1'b0;
      end else begin
        wait_cycles = draw_gap();
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.idx     = out_body_index;
      got.fx      = out_force_x;
      got.fy      = out_force_y;
      got.dropped = out_dropped;
      got.last    = out_last_result;
      sb.check_force(got);
      @(negedge clk);
    end
  end

  initial begin
    int          n;
    logic [31:0] g;
    logic [31:0] d;
    sb = new();
    hold_req = 1'b0;
    bodies_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_body_mass = '0;
    in_last_body = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRAV_CONST;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes at reset defaults, with one coincident pair, then a single-body set.
    send_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_body(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001, 1'b1);
    send_body(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1);
    drain();

    // Close heavy pairs with the largest constant: force saturates both ways.
    write_cfg(REG_GRAV_CONST, 32'hFFFF_FFFF);
    write_cfg(REG_MIN_DIST, 32'h0000_0000);
    send_body(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b0);
    send_body(32'h0000_0008, 32'h0000_0000, 16'hFFFF, 1'b0);
    send_body(32'h0000_0000, 32'hFFFF_FFF8, 16'hFFFF, 1'b0);
    send_body(32'h0000_0000, 32'h0000_0000, 16'h8000, 1'b1);
    drain();

    // Hold the results back while the next set is offered.
    write_cfg(REG_GRAV_CONST, 32'h0000_0000);
    hold_req = 1'b1;
    send_body(32'h0001_0000, 32'hFFFF_0000, 16'h0040, 1'b0);
    send_body(32'hFFFF_0000, 32'h0001_0000, 16'h0040, 1'b1);
    send_body(32'h1234_5678, 32'h8765_4321, 16'h5555, 1'b0);
    send_body(32'hEDCB_A987, 32'h789A_BCDE, 16'hAAAA, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin g = GRAV_RST; d = MIN_DIST_RST; end
        1: begin g = $urandom(); d = $urandom_range(0, 200); end
        2: begin g = 32'hFFFF_FFFF; d = 32'h8000_0000 | $urandom_range(0, 40); end
        default: begin g = $urandom(); d = $urandom_range(0, 32'h0010_0000); end
      endcase
      write_cfg(REG_GRAV_CONST, g);
      write_cfg(REG_MIN_DIST, d);
      for (int s = 0; s < 3; s++) begin
        n = $urandom_range(1, 5);
        random_set(n, 1'($urandom_range(0, 1)));
      end
      drain();
    end

    // Overflowing set; a large cutoff keeps every pair cheap.
    write_cfg(REG_MIN_DIST, 32'h7FFF_FFFF);
    for (int i = 0; i < NBODY + 2; i++)
      send_body($urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000,
                $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000,
                MASS_W'($urandom_range(0, 65535)), i == NBODY + 1);
    drain();

    $display("Covered %0d bodies in %0d sets, %0d force results checked.",
             bodies_sent, sb.n_sets, sb.n_checked);
    if (sb.errors == 0 && sb.pending_forces.size() == 0) begin
      $display("[nbody_pairwise_gravity_force_unit] OK");
    end else begin
      $display("[nbody_pairwise_gravity_force_unit] ERROR");
    end
    $finish;
  end
endmodule
